// ----- hw/rtl/tspf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tspf_pkg;

  localparam int unsigned NUM_STATES = 16;

  localparam logic [1:0] STATUS_PATH     = 2'd0;
  localparam logic [1:0] STATUS_HERE     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [3:0] from_state;
    logic [3:0] to_state;
  } req_t;

  typedef struct packed {
    logic       tms;
    logic [3:0] step_index;
    logic       last;
    logic [1:0] status;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       expand;
    logic       walk_init;
    logic       walk_step;
    logic       emit_bit;
    logic       emit_status;
    logic [1:0] status_code;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic req_same;
    logic found;
    logic exhausted;
    logic walk_done;
    logic walk_over;
    logic emit_last;
  } sts_t;

  // Next TAP controller state for a given TMS value.
  function automatic logic [3:0] tap_next(input logic [3:0] st, input logic tms);
    logic [3:0] n0;
    logic [3:0] n1;
    unique case (st)
      4'd0:    begin n0 = 4'd1;  n1 = 4'd0;  end
      4'd1:    begin n0 = 4'd1;  n1 = 4'd2;  end
      4'd2:    begin n0 = 4'd3;  n1 = 4'd9;  end
      4'd3:    begin n0 = 4'd4;  n1 = 4'd5;  end
      4'd4:    begin n0 = 4'd4;  n1 = 4'd5;  end
      4'd5:    begin n0 = 4'd6;  n1 = 4'd8;  end
      4'd6:    begin n0 = 4'd6;  n1 = 4'd7;  end
      4'd7:    begin n0 = 4'd4;  n1 = 4'd8;  end
      4'd8:    begin n0 = 4'd1;  n1 = 4'd2;  end
      4'd9:    begin n0 = 4'd10; n1 = 4'd0;  end
      4'd10:   begin n0 = 4'd11; n1 = 4'd12; end
      4'd11:   begin n0 = 4'd11; n1 = 4'd12; end
      4'd12:   begin n0 = 4'd13; n1 = 4'd15; end
      4'd13:   begin n0 = 4'd13; n1 = 4'd14; end
      4'd14:   begin n0 = 4'd11; n1 = 4'd15; end
      default: begin n0 = 4'd1;  n1 = 4'd2;  end
    endcase
    return tms ? n1 : n0;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tap_state_path_finder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Signals                         Transfer when
// --------   -----------------------------   -----------------------------
// request    start, busy, req                start high while busy is low
// result     result_valid, result            result_valid high (one cycle)
// config     cfg_wr_en, cfg_wr_data          cfg_wr_en high
//
// A request whose start equals its target, or any request while the step limit is
// zero, answers with one status transfer in the cycle after it is taken.
// A search visits each queued TAP state once per TMS edge and stops as soon as the
// target is discovered; backtracking then stores the path bits, each sent as one
// transfer, and a path longer than the step limit gets a too-long status instead.
// Reset is synchronous and restores a step limit of 15.
// The receiver cannot stall; results are presented for exactly one cycle each.

module tap_state_path_finder_core
  import tspf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire req_t       req,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  output res_t            result,
  output logic            result_valid
);

  cmd_t cmd;
  sts_t sts;

  tspf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tspf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_valid)
    else $error("An accepted request produced neither work nor a result.");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("A non-final result was sent with the block idle.");

endmodule

`default_nettype wire

// ----- hw/rtl/tspf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tspf_ctrl
  import tspf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.status_code = STATUS_TOO_LONG;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          priority if (sts.limit_zero) begin
            cmd.emit_status = 1'b1;
          end else if (sts.req_same) begin
            cmd.emit_status = 1'b1;
            cmd.status_code = STATUS_HERE;
          end else begin
            cmd.load = 1'b1;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        priority if (sts.found) begin
          cmd.walk_init = 1'b1;
          state_next = ST_WALK;
        end else if (sts.exhausted) begin
          cmd.emit_status = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.expand = 1'b1;
        end
      end
      ST_WALK: begin
        priority if (sts.walk_done) begin
          state_next = ST_EMIT;
        end else if (sts.walk_over) begin
          cmd.emit_status = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit_bit = 1'b1;
        if (sts.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == ST_IDLE) && start)
    else $error("Search loaded outside of an accepted request.");

  a_emit_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && sts.emit_last |=> (state == ST_IDLE))
    else $error("Controller did not return to idle after the last bit.");

endmodule

`default_nettype wire

// ----- hw/rtl/tspf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tspf_dp
  import tspf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire req_t       req,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  output res_t            result,
  output logic            result_valid
);

  logic [3:0] step_limit;
  logic [3:0] from_q;
  logic [3:0] to_q;

  logic [NUM_STATES-1:0] visited;
  logic [3:0]            parent [NUM_STATES];
  logic                  pedge  [NUM_STATES];
  logic [3:0]            queue  [NUM_STATES];
  logic                  path_bits [NUM_STATES];

  logic [4:0] head;
  logic [4:0] tail;
  logic       edge_sel;
  logic [3:0] walk_st;
  logic [4:0] len;
  logic [3:0] emit_idx;

  logic [3:0] cur;
  logic [3:0] node;
  logic       node_new;
  logic [3:0] bit_addr;
  logic       emit_last;

  assign cur       = queue[head[3:0]];
  assign node      = tap_next(cur, edge_sel);
  assign node_new  = !visited[node] && !tail[4];
  assign bit_addr  = len[3:0] - 4'd1 - emit_idx;
  assign emit_last = ({1'b0, emit_idx} + 5'd1) == len;

  always_comb begin
    sts.limit_zero = (step_limit == 4'd0);
    sts.req_same   = (req.from_state == req.to_state);
    sts.found      = visited[to_q];
    sts.exhausted  = (head == tail);
    sts.walk_done  = (walk_st == from_q);
    sts.walk_over  = (len >= {1'b0, step_limit}) || len[4];
    sts.emit_last  = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= 4'd15;
    end else if (cfg_wr_en) begin
      step_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (cmd.load) begin
      visited <= NUM_STATES'(1) << req.from_state;
    end else if (cmd.expand && node_new) begin
      visited[node] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      from_q   <= req.from_state;
      to_q     <= req.to_state;
      queue[0] <= req.from_state;
      head     <= 5'd0;
      tail     <= 5'd1;
      edge_sel <= 1'b0;
    end else if (cmd.expand) begin
      edge_sel <= !edge_sel;
      if (edge_sel) begin
        head <= head + 5'd1;
      end
      if (node_new) begin
        parent[node]       <= cur;
        pedge[node]        <= edge_sel;
        queue[tail[3:0]]   <= node;
        tail               <= tail + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_st  <= to_q;
      len      <= 5'd0;
      emit_idx <= 4'd0;
    end else if (cmd.walk_step) begin
      path_bits[len[3:0]] <= pedge[walk_st];
      walk_st             <= parent[walk_st];
      len                 <= len + 5'd1;
    end else if (cmd.emit_bit) begin
      emit_idx <= emit_idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_bit || cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      result.tms        <= 1'b0;
      result.step_index <= 4'd0;
      result.last       <= 1'b1;
      result.status     <= cmd.status_code;
    end else if (cmd.emit_bit) begin
      result.tms        <= path_bits[bit_addr];
      result.step_index <= emit_idx;
      result.last       <= emit_last;
      result.status     <= STATUS_PATH;
    end
  end

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STATUS_PATH) |->
      result.last && !result.tms && (result.step_index == 4'd0))
    else $error("A status result must be a single final transfer.");

  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> !len[4])
    else $error("Backtrack ran past the path store.");

endmodule

`default_nettype wire
